FILE: design/pcat_pkg.sv
// shared types and constants for the pci configuration access translator
// no dependencies; imported by every module of the block
`default_nettype none

package pcat_pkg;

  localparam int SEGMENT_ENTRIES = 8;
  localparam int SEG_IDX_W = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
  localparam int SEG_CNT_W = $clog2(SEGMENT_ENTRIES + 1);

  localparam logic [12:0] LEGACY_SPACE = 13'd256;
  localparam logic [12:0] EXT_SPACE    = 13'd4096;
  localparam logic [63:0] NARROW_LIMIT = 64'h0000_0000_FFFF_EFFF;

  // configuration register indexes
  localparam logic CFG_SEG_COUNT = 1'b0;
  localparam logic CFG_NARROW    = 1'b1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XLATE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ACCESS = 3'd1,
    ST_NO_SEGMENT = 3'd2,
    ST_BUS_RANGE  = 3'd3,
    ST_TOO_BIG    = 3'd4
  } status_t;

  // item as accepted on the input channel
  typedef struct packed {
    logic        command;
    logic [2:0]  entry_index;
    logic [63:0] entry_base;
    logic [15:0] entry_segment;
    logic [7:0]  entry_start_bus;
    logic [7:0]  entry_end_bus;
    logic [15:0] access_segment;
    logic [7:0]  access_bus;
    logic [4:0]  access_device;
    logic [2:0]  access_function;
    logic [11:0] access_offset;
    logic [1:0]  access_size;
  } req_t;

  // after segment lookup
  typedef struct packed {
    logic        is_load;
    logic        legacy;
    logic        seg_err;
    logic [63:0] base;
    logic [7:0]  first_bus;
    logic [7:0]  last_bus;
    logic [7:0]  bus;
    logic [4:0]  dev;
    logic [2:0]  fn;
    logic [11:0] off;
    logic [1:0]  size;
  } look_t;

  // after range and access checks
  typedef struct packed {
    logic        is_load;
    logic        legacy;
    logic        seg_err;
    logic        bus_err;
    logic        acc_bad;
    logic [63:0] addr_base;
    logic [11:0] off;
  } chk_t;

  // result item
  typedef struct packed {
    status_t     status;
    logic [63:0] address;
    logic [1:0]  byte_lane;
    logic        uses_extended;
  } res_t;

endpackage

`default_nettype wire

FILE: design/pcat_lookup.sv
// stage two: segment table storage, load writes and first-match lookup
// depends on pcat_pkg
`default_nettype none

module pcat_lookup
  import pcat_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] seg_count_i,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire req_t       in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output look_t           out_item
);

  logic [63:0] base_r   [SEGMENT_ENTRIES];
  logic [15:0] number_r [SEGMENT_ENTRIES];
  logic [7:0]  first_r  [SEGMENT_ENTRIES];
  logic [7:0]  last_r   [SEGMENT_ENTRIES];

  logic                       valid_r;
  look_t                      item_r;
  look_t                      look_nxt;
  logic [SEG_CNT_W-1:0]       count;
  logic [SEGMENT_ENTRIES-1:0] match;
  logic [SEG_IDX_W-1:0]       hit_idx;
  logic                       found;
  logic                       is_load;
  logic                       wr_en;
  logic [SEG_IDX_W-1:0]       wr_idx;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  assign is_load = (in_item.command == CMD_LOAD);
  assign wr_idx  = SEG_IDX_W'(in_item.entry_index);
  assign wr_en   = in_valid && in_ready && is_load &&
                   (int'(in_item.entry_index) < SEGMENT_ENTRIES);

  always_comb begin
    if (int'(seg_count_i) > SEGMENT_ENTRIES) begin
      count = SEG_CNT_W'(SEGMENT_ENTRIES);
    end else begin
      count = SEG_CNT_W'(seg_count_i);
    end
    for (int i = 0; i < SEGMENT_ENTRIES; i++) begin
      match[i] = (i < int'(count)) && (number_r[i] == in_item.access_segment);
    end
    // lowest matching slot wins
    found   = 1'b0;
    hit_idx = '0;
    for (int i = SEGMENT_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found   = 1'b1;
        hit_idx = SEG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    look_nxt.is_load   = is_load;
    look_nxt.legacy    = (count == '0);
    look_nxt.seg_err   = (count == '0) ? (in_item.access_segment != 16'd0) : !found;
    look_nxt.base      = base_r[hit_idx];
    look_nxt.first_bus = first_r[hit_idx];
    look_nxt.last_bus  = last_r[hit_idx];
    look_nxt.bus       = in_item.access_bus;
    look_nxt.dev       = in_item.access_device;
    look_nxt.fn        = in_item.access_function;
    look_nxt.off       = in_item.access_offset;
    look_nxt.size      = in_item.access_size;
  end

  // table is written as the load item enters this stage, so later items see it and earlier ones do not
  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_r[wr_idx]   <= in_item.entry_base;
      number_r[wr_idx] <= in_item.entry_segment;
      first_r[wr_idx]  <= in_item.entry_start_bus;
      last_r[wr_idx]   <= in_item.entry_end_bus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= look_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/pcat_resolve.sv
// stage three: bus range check, access width checks, base address sum
// depends on pcat_pkg
`default_nettype none

module pcat_resolve
  import pcat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire look_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output chk_t       out_item
);

  logic        valid_r;
  chk_t        item_r;
  chk_t        chk_nxt;
  logic        bus_err;
  logic [7:0]  bus_rel;
  logic [63:0] ext_base;
  logic [63:0] legacy_word;

  function automatic logic access_bad(input logic [11:0] off, input logic [1:0] size,
                                      input logic [12:0] space);
    logic [12:0] len;
    logic        bad;
    case (size)
      2'd0:    len = 13'd1;
      2'd1:    len = 13'd2;
      2'd2:    len = 13'd4;
      default: len = 13'd0;
    endcase
    bad = (size == 2'd3) ||
          ((size == 2'd1) && off[0]) ||
          ((size == 2'd2) && (off[1:0] != 2'b00)) ||
          (({1'b0, off} + len) > space);
    return bad;
  endfunction

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  assign bus_err  = (in_item.bus < in_item.first_bus) || (in_item.bus > in_item.last_bus);
  assign bus_rel  = in_item.bus - in_item.first_bus;
  // bus at 1 MiB, device at 32 KiB, function at 4 KiB
  assign ext_base = in_item.base +
                    {36'd0, bus_rel, in_item.dev, in_item.fn, 12'd0};
  assign legacy_word = {32'd0, 1'b1, 7'd0, in_item.bus, in_item.dev, in_item.fn,
                        in_item.off[7:2], 2'b00};

  always_comb begin
    chk_nxt.is_load   = in_item.is_load;
    chk_nxt.legacy    = in_item.legacy;
    chk_nxt.seg_err   = in_item.seg_err;
    chk_nxt.bus_err   = !in_item.legacy && bus_err;
    chk_nxt.acc_bad   = access_bad(in_item.off, in_item.size,
                                   in_item.legacy ? LEGACY_SPACE : EXT_SPACE);
    chk_nxt.addr_base = in_item.legacy ? legacy_word : ext_base;
    chk_nxt.off       = in_item.off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= chk_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/pcat_output.sv
// last stage: address size check, offset add, status priority, result register
// depends on pcat_pkg
`default_nettype none

module pcat_output
  import pcat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic narrow_i,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire chk_t in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_item
);

  logic        valid_r;
  res_t        item_r;
  res_t        res_nxt;
  logic        too_big;
  logic [63:0] ext_addr;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  assign too_big  = narrow_i && (in_item.addr_base > NARROW_LIMIT);
  assign ext_addr = in_item.addr_base + {52'd0, in_item.off};

  // error order: segment, bus, address size, access
  always_comb begin
    res_nxt.status        = ST_OK;
    res_nxt.address       = 64'd0;
    res_nxt.byte_lane     = 2'd0;
    res_nxt.uses_extended = 1'b0;
    if (!in_item.is_load) begin
      if (in_item.seg_err) begin
        res_nxt.status = ST_NO_SEGMENT;
      end else if (in_item.bus_err) begin
        res_nxt.status = ST_BUS_RANGE;
      end else if (!in_item.legacy && too_big) begin
        res_nxt.status = ST_TOO_BIG;
      end else if (in_item.acc_bad) begin
        res_nxt.status = ST_BAD_ACCESS;
      end else if (in_item.legacy) begin
        res_nxt.address   = in_item.addr_base;
        res_nxt.byte_lane = in_item.off[1:0];
      end else begin
        res_nxt.address       = ext_addr;
        res_nxt.uses_extended = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= res_nxt;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (item_r.status != ST_OK)) |->
      ((item_r.address == 64'd0) && (item_r.byte_lane == 2'd0) && !item_r.uses_extended))
    else $error("error result carries a nonzero address");

  a_ext_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && item_r.uses_extended) |->
      ((item_r.byte_lane == 2'd0) && (item_r.status == ST_OK)))
    else $error("extended result with a byte lane or an error");

  a_load_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.is_load) |=>
      (valid_r && (item_r.status == ST_OK) && (item_r.address == 64'd0)))
    else $error("load item gave a nonzero result");

endmodule

`default_nettype wire

FILE: design/pci_config_access_translator_core.sv
// pci configuration access translator: ecam and legacy port address forming
// depends on pcat_pkg, pcat_lookup, pcat_resolve, pcat_output
//
// usage
//   the in_ channel takes one item per cycle: command 0 loads a segment table
//   slot from the entry_ fields, command 1 translates the access_ fields.
//   every item yields one result on the out_ channel in order; a load gives
//   status ok and zero fields. cfg_ writes set the segment count (index 0)
//   and the narrow address space flag (index 1); cfg_ready is always high.
//   the user must make writes only while no item is in flight (unenforced).
// stages and throughput
//   four register stages (input, lookup, checks and base sum, final add and
//   status); the input stage loads at the accepting edge, and a result moves
//   on through the lookup, checks and final registers to out_valid. one item
//   per cycle is sustained while out_ready stays high. the 64-bit adds and the
//   eight-way segment compare set the stage depth.
// reset and stalls
//   reset empties the pipeline and clears both config registers; the segment
//   table holds nothing meaningful until slots are loaded. when out_ready is
//   low the stages fill up behind the output register and in_ready drops only
//   once every stage holds an item; nothing is lost or repeated.
`default_nettype none

module pci_config_access_translator_core
  import pcat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [2:0]  in_entry_index,
  input  wire logic [63:0] in_entry_base,
  input  wire logic [15:0] in_entry_segment,
  input  wire logic [7:0]  in_entry_start_bus,
  input  wire logic [7:0]  in_entry_end_bus,
  input  wire logic [15:0] in_access_segment,
  input  wire logic [7:0]  in_access_bus,
  input  wire logic [4:0]  in_access_device,
  input  wire logic [2:0]  in_access_function,
  input  wire logic [11:0] in_access_offset,
  input  wire logic [1:0]  in_access_size,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [63:0]      out_address,
  output logic [1:0]       out_byte_lane,
  output logic             out_uses_extended
);

  logic [3:0] seg_count_r;
  logic       narrow_r;

  logic  s1_valid_r;
  req_t  s1_item_r;
  req_t  req_nxt;
  logic  lk_in_ready;
  logic  lk_valid;
  look_t lk_item;
  logic  rs_in_ready;
  logic  rs_valid;
  chk_t  rs_item;
  logic  op_in_ready;
  res_t  op_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= 4'd0;
      narrow_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEG_COUNT: seg_count_r <= cfg_data;
        CFG_NARROW:    narrow_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    req_nxt.command         = in_command;
    req_nxt.entry_index     = in_entry_index;
    req_nxt.entry_base      = in_entry_base;
    req_nxt.entry_segment   = in_entry_segment;
    req_nxt.entry_start_bus = in_entry_start_bus;
    req_nxt.entry_end_bus   = in_entry_end_bus;
    req_nxt.access_segment  = in_access_segment;
    req_nxt.access_bus      = in_access_bus;
    req_nxt.access_device   = in_access_device;
    req_nxt.access_function = in_access_function;
    req_nxt.access_offset   = in_access_offset;
    req_nxt.access_size     = in_access_size;
  end

  assign in_ready = !s1_valid_r || lk_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item_r <= req_nxt;
    end
  end

  pcat_lookup u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .seg_count_i (seg_count_r),
    .in_valid    (s1_valid_r),
    .in_ready    (lk_in_ready),
    .in_item     (s1_item_r),
    .out_valid   (lk_valid),
    .out_ready   (rs_in_ready),
    .out_item    (lk_item)
  );

  pcat_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lk_valid),
    .in_ready  (rs_in_ready),
    .in_item   (lk_item),
    .out_valid (rs_valid),
    .out_ready (op_in_ready),
    .out_item  (rs_item)
  );

  pcat_output u_output (
    .clk       (clk),
    .rst_n     (rst_n),
    .narrow_i  (narrow_r),
    .in_valid  (rs_valid),
    .in_ready  (op_in_ready),
    .in_item   (rs_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (op_item)
  );

  assign out_status        = op_item.status;
  assign out_address       = op_item.address;
  assign out_byte_lane     = op_item.byte_lane;
  assign out_uses_extended = op_item.uses_extended;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted item missing from the input stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !lk_in_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage changed while stalled");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> (s1_valid_r && lk_valid && rs_valid && out_valid && !out_ready))
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire
